// File: hdl/swsfr_pkg.sv
// Shared types and constants of the sliding-window sender.
`default_nettype none

package swsfr_pkg;

    // Fixed field widths
    localparam int SEQ_W  = 16;
    localparam int PAY_W  = 64;
    localparam int WLEN_W = 4;

    // Input request packing in s_tdata, lowest bit first
    localparam int S_PAY_LSB   = 0;
    localparam int S_ACK_LSB   = S_PAY_LSB + PAY_W;
    localparam int S_OK_BIT    = S_ACK_LSB + SEQ_W;
    localparam int S_TMR_LSB   = S_OK_BIT + 1;
    localparam int S_USED_W    = S_TMR_LSB + SEQ_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Result packing in m_tdata, lowest bit first
    localparam int M_SEQ_LSB   = 0;
    localparam int M_PAY_LSB   = M_SEQ_LSB + SEQ_W;
    localparam int M_FULL_BIT  = M_PAY_LSB + PAY_W;
    localparam int M_USED_W    = M_FULL_BIT + 1;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Window length after reset
    localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd4;

    // Duplicate ACK tracking
    localparam logic [2:0] DUP_TRIGGER  = 3'd4;
    localparam logic [2:0] DUP_SATURATE = 3'd5;

    // Event codes on s_tuser
    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TIMER = 2'd2
    } op_t;

    // Result codes on m_tuser
    typedef enum logic [1:0] {
        KIND_REFUSED  = 2'd0,
        KIND_TRANSMIT = 2'd1,
        KIND_START    = 2'd2,
        KIND_STOP     = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// File: hdl/sliding_window_sender_fast_retransmit.sv
// Sliding-window sender with cumulative ACKs, timer control and fast retransmit.
// Each request is held in the input register, then loaded into the result queue that drives the results.
// A request yields up to three results; the single result queue shifts out one result
// per cycle while m_tready is high and takes the next request as its last leaves.
// Reset: window and sequence state cleared, window length set to 4, last ACK set to
// all ones and duplicate count cleared; the slot memory is not cleared.
`default_nettype none

module sliding_window_sender_fast_retransmit #(
    parameter int SLOTS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Window length register write
    input  wire logic                             cfg_we,
    input  wire logic [swsfr_pkg::WLEN_W-1:0]     cfg_wdata,
    // Event requests
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: payload_word[63:0], ack_number[79:64], checksum_ok[80], timer_seq[96:81]
    input  wire logic [swsfr_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [1:0]                       s_tuser,
    // Results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: packet_seq[15:0], packet_payload[79:16], window_full[80]
    output logic [swsfr_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: result_kind[1:0]
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast
);

    import swsfr_pkg::*;

    localparam int IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam logic [SEQ_W-1:0] SLOTS_SEQ = SEQ_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    // Reciprocal for remainder by SLOTS of a sequence number
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SLOTS + 64'd1);
    localparam int PROD_W = SEQ_W + 33;
    localparam int M_PAD_W = M_TDATA_W - M_USED_W;

    // Input register
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic [PAY_W-1:0]     in_pay_reg;
    logic [SEQ_W-1:0]     in_ack_reg;
    logic                 in_ok_reg;
    logic [SEQ_W-1:0]     in_tmr_reg;
    logic [SEQ_W-1:0]     in_tq_reg;
    logic [PROD_W-1:0]    tmr_prod;

    // Sender state
    logic [WLEN_W-1:0]    wlen_reg;
    logic [SEQ_W-1:0]     base_reg, base_next;
    logic [SEQ_W-1:0]     nseq_reg, nseq_next;
    logic [IDX_W-1:0]     base_idx_reg, base_idx_next;
    logic [IDX_W-1:0]     nidx_reg, nidx_next;
    logic                 full_reg, full_next;
    logic [SEQ_W-1:0]     prev_ack_reg, prev_ack_next;
    logic [2:0]           dup_reg, dup_next;

    // Result queue, head at entry 0
    kind_t                q_kind_reg [3];
    kind_t                q_kind_next [3];
    logic [SEQ_W-1:0]     q_seq_reg [3];
    logic [SEQ_W-1:0]     q_seq_next [3];
    logic [PAY_W-1:0]     q_pay_reg [3];
    logic [PAY_W-1:0]     q_pay_next [3];
    logic [2:0]           q_mem_reg, q_mem_next;
    logic [1:0]           q_count_reg, q_count_next;
    logic                 q_full_reg, q_full_next;

    // Results of the current request
    kind_t                r_kind [3];
    logic [SEQ_W-1:0]     r_seq [3];
    logic [PAY_W-1:0]     r_pay [3];
    logic [2:0]           r_mem;
    logic [1:0]           r_n;

    // Slot memory
    logic [SEQ_W+PAY_W-1:0] slot_mem [SLOTS];
    logic [SEQ_W+PAY_W-1:0] rd_data_reg;
    logic                   mem_we;
    logic                   mem_rd_en;
    logic [IDX_W-1:0]       rd_addr;

    logic                 pop;
    logic                 load;
    logic [SEQ_W-1:0]     win;
    logic [SEQ_W-1:0]     inflight;
    logic [SEQ_W-1:0]     offset;
    logic [SEQ_W-1:0]     ack_inc;
    logic [SEQ_W-1:0]     nseq_inc;
    logic [SEQ_W-1:0]     base_idx_sum;
    logic [SEQ_W-1:0]     tmr_rem;
    logic [IDX_W-1:0]     tmr_idx;
    logic [2:0]           dup_sat;

    // Handshake
    assign pop      = m_tvalid && m_tready;
    assign load     = in_valid_reg && ((q_count_reg == 2'd0) || ((q_count_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || load;

    // Quotient of the timer tag by SLOTS, registered with the request
    assign tmr_prod = PROD_W'(s_tdata[S_TMR_LSB +: SEQ_W]) * PROD_W'(RECIP);

    // Capture request control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Capture request fields
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= op_t'(s_tuser);
            in_pay_reg <= s_tdata[S_PAY_LSB +: PAY_W];
            in_ack_reg <= s_tdata[S_ACK_LSB +: SEQ_W];
            in_ok_reg  <= s_tdata[S_OK_BIT];
            in_tmr_reg <= s_tdata[S_TMR_LSB +: SEQ_W];
            in_tq_reg  <= tmr_prod[32 +: SEQ_W];
        end
    end

    // Effective window and serial distances
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            win = SEQ_W'(1);
        end
        else if (SEQ_W'(wlen_reg) > SLOTS_SEQ)
        begin
            win = SLOTS_SEQ;
        end
        else
        begin
            win = SEQ_W'(wlen_reg);
        end
    end

    assign inflight = nseq_reg - base_reg;
    assign offset   = in_ack_reg - base_reg;
    assign ack_inc  = in_ack_reg + SEQ_W'(1);
    assign nseq_inc = nseq_reg + SEQ_W'(1);
    assign dup_sat  = (dup_reg < DUP_SATURATE) ? dup_reg + 3'd1 : dup_reg;
    assign tmr_rem  = in_tmr_reg - SEQ_W'(in_tq_reg * SLOTS_SEQ);
    assign tmr_idx  = IDX_W'(tmr_rem);
    assign base_idx_sum = SEQ_W'(base_idx_reg) + offset + SEQ_W'(1);

    // Process one request: update state and build its results
    always_comb
    begin
        base_next     = base_reg;
        nseq_next     = nseq_reg;
        base_idx_next = base_idx_reg;
        nidx_next     = nidx_reg;
        full_next     = full_reg;
        prev_ack_next = prev_ack_reg;
        dup_next      = dup_reg;
        mem_we        = 1'b0;
        mem_rd_en     = 1'b0;
        rd_addr       = base_idx_reg;
        r_n           = 2'd0;
        r_mem         = 3'b000;
        for (int i = 0; i < 3; i++)
        begin
            r_kind[i] = KIND_REFUSED;
            r_seq[i]  = '0;
            r_pay[i]  = '0;
        end

        if (load)
        begin
            case (in_op_reg)
                OP_SEND:
                begin
                    if (full_reg || (inflight >= win))
                    begin
                        r_n = 2'd1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (base_reg == nseq_reg)
                        begin
                            r_kind[0] = KIND_START;
                            r_seq[0]  = nseq_reg;
                            r_kind[1] = KIND_TRANSMIT;
                            r_seq[1]  = nseq_reg;
                            r_pay[1]  = in_pay_reg;
                            r_n       = 2'd2;
                        end
                        else
                        begin
                            r_kind[0] = KIND_TRANSMIT;
                            r_seq[0]  = nseq_reg;
                            r_pay[0]  = in_pay_reg;
                            r_n       = 2'd1;
                        end
                        nseq_next = nseq_inc;
                        // Slot index restarts at zero after the last slot or where the sequence wraps
                        if ((nseq_inc == '0) || (nidx_reg == LAST_IDX))
                        begin
                            nidx_next = '0;
                        end
                        else
                        begin
                            nidx_next = nidx_reg + IDX_W'(1);
                        end
                        full_next = ((nseq_inc - base_reg) == win);
                    end
                end
                OP_ACK:
                begin
                    if (in_ok_reg && !offset[SEQ_W-1])
                    begin
                        // Advance the window on an ACK inside the flight
                        if (offset < inflight)
                        begin
                            base_next = ack_inc;
                            if (ack_inc < base_reg)
                            begin
                                base_idx_next = IDX_W'(ack_inc);
                            end
                            else if (base_idx_sum >= SLOTS_SEQ)
                            begin
                                base_idx_next = IDX_W'(base_idx_sum - SLOTS_SEQ);
                            end
                            else
                            begin
                                base_idx_next = IDX_W'(base_idx_sum);
                            end
                            r_kind[0] = KIND_STOP;
                            r_seq[0]  = base_reg;
                            r_n       = 2'd1;
                            if (ack_inc != nseq_reg)
                            begin
                                r_kind[1] = KIND_START;
                                r_seq[1]  = ack_inc;
                                r_n       = 2'd2;
                            end
                            full_next = 1'b0;
                        end
                    end
                    else if (in_ack_reg == prev_ack_reg)
                    begin
                        // Count duplicates, retransmit the base slot on the trigger
                        dup_next = dup_sat;
                        if (dup_sat == DUP_TRIGGER)
                        begin
                            r_kind[0] = KIND_STOP;
                            r_seq[0]  = ack_inc;
                            r_kind[1] = KIND_START;
                            r_seq[1]  = ack_inc;
                            r_kind[2] = KIND_TRANSMIT;
                            r_mem[2]  = 1'b1;
                            r_n       = 2'd3;
                            mem_rd_en = 1'b1;
                            rd_addr   = base_idx_reg;
                        end
                    end
                    else
                    begin
                        prev_ack_next = in_ack_reg;
                        dup_next      = 3'd1;
                    end
                end
                OP_TIMER:
                begin
                    r_kind[0] = KIND_STOP;
                    r_seq[0]  = in_tmr_reg;
                    r_kind[1] = KIND_START;
                    r_seq[1]  = in_tmr_reg;
                    r_kind[2] = KIND_TRANSMIT;
                    r_mem[2]  = 1'b1;
                    r_n       = 2'd3;
                    mem_rd_en = 1'b1;
                    rd_addr   = tmr_idx;
                end
                default:
                begin
                    r_n = 2'd0;
                end
            endcase
        end
    end

    // Load a new result set or shift the queue
    always_comb
    begin
        q_count_next = q_count_reg;
        q_full_next  = q_full_reg;
        q_mem_next   = q_mem_reg;
        for (int i = 0; i < 3; i++)
        begin
            q_kind_next[i] = q_kind_reg[i];
            q_seq_next[i]  = q_seq_reg[i];
            q_pay_next[i]  = q_pay_reg[i];
        end

        if (load)
        begin
            q_count_next = r_n;
            q_full_next  = full_next;
            q_mem_next   = r_mem;
            for (int i = 0; i < 3; i++)
            begin
                q_kind_next[i] = r_kind[i];
                q_seq_next[i]  = r_seq[i];
                q_pay_next[i]  = r_pay[i];
            end
        end
        else if (pop)
        begin
            q_count_next = q_count_reg - 2'd1;
            q_mem_next   = {1'b0, q_mem_reg[2:1]};
            for (int i = 0; i < 2; i++)
            begin
                q_kind_next[i] = q_kind_reg[i+1];
                q_seq_next[i]  = q_seq_reg[i+1];
                q_pay_next[i]  = q_pay_reg[i+1];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg     <= WLEN_RESET;
            base_reg     <= '0;
            nseq_reg     <= '0;
            base_idx_reg <= '0;
            nidx_reg     <= '0;
            full_reg     <= 1'b0;
            prev_ack_reg <= '1;
            dup_reg      <= '0;
            q_count_reg  <= '0;
            q_full_reg   <= 1'b0;
            q_mem_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
            end
            base_reg     <= base_next;
            nseq_reg     <= nseq_next;
            base_idx_reg <= base_idx_next;
            nidx_reg     <= nidx_next;
            full_reg     <= full_next;
            prev_ack_reg <= prev_ack_next;
            dup_reg      <= dup_next;
            q_count_reg  <= q_count_next;
            q_full_reg   <= q_full_next;
            q_mem_reg    <= q_mem_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_kind_reg[i] <= q_kind_next[i];
            q_seq_reg[i]  <= q_seq_next[i];
            q_pay_reg[i]  <= q_pay_next[i];
        end
    end

    // Slot memory: store sent packets, read the slot to retransmit
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[nidx_reg] <= {nseq_reg, in_pay_reg};
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Drive the result channel from the queue head
    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tlast  = (q_count_reg == 2'd1);
    assign m_tuser  = q_kind_reg[0];
    assign m_tdata  = {{M_PAD_W{1'b0}},
                       q_full_reg,
                       q_mem_reg[0] ? rd_data_reg[PAY_W-1:0] : q_pay_reg[0],
                       q_mem_reg[0] ? rd_data_reg[PAY_W +: SEQ_W] : q_seq_reg[0]};

    // Duplicate tracker never passes its saturation value
    assert property (@(posedge clk) disable iff (!rst_n) dup_reg <= DUP_SATURATE)
        else $error("duplicate count above saturation");

    // Packets in flight never exceed the slot count
    assert property (@(posedge clk) disable iff (!rst_n) inflight <= SLOTS_SEQ)
        else $error("packets in flight exceed slots");

    // A retransmit from memory is always the last result of its request
    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_tvalid && q_mem_reg[0]) |-> (q_count_reg == 2'd1))
        else $error("retransmit not last in result set");

    // An accepted window update leaves the full flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
                     (load && (base_next != base_reg)) |=> !full_reg)
        else $error("window full after base advance");

endmodule

`default_nettype wire
